### rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, pre, post)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### rtl/ebcc_pkg.sv
package ebcc_pkg;

  // input op codes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_REQUEST   = 3'd1;
  localparam logic [2:0] OP_READ_ALL  = 3'd2;
  localparam logic [2:0] OP_CHIP_BYTE = 3'd3;
  localparam logic [2:0] OP_BUF_WRITE = 3'd4;
  localparam logic [2:0] OP_BUF_READ  = 3'd5;
  localparam logic [2:0] OP_STATUS    = 3'd6;

  // chip operation in progress
  localparam logic [1:0] OPER_IDLE  = 2'd0;
  localparam logic [1:0] OPER_ERASE = 2'd1;
  localparam logic [1:0] OPER_WRITE = 2'd2;
  localparam logic [1:0] OPER_READ  = 2'd3;

  // chip commands
  localparam logic [1:0] CMD_DESELECT = 2'd0;
  localparam logic [1:0] CMD_ERASE    = 2'd1;
  localparam logic [1:0] CMD_WRITE    = 2'd2;
  localparam logic [1:0] CMD_READ     = 2'd3;

  localparam logic KIND_CHIP = 1'b0;
  localparam logic KIND_HOST = 1'b1;

  // batch layout on the chip
  localparam logic [5:0] FIRST_ADDR0 = 6'h02;
  localparam logic [5:0] FIRST_ADDR1 = 6'h1E;
  localparam logic [5:0] SUM_ADDR0   = 6'h1D;
  localparam logic [5:0] SUM_ADDR1   = 6'h3E;
  localparam logic [5:0] LAST_IDX0   = 6'd26;
  localparam logic [5:0] LAST_IDX1   = 6'd31;

  localparam int PC_W = 5;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] batch_bits;
    logic       zero_fill;
    logic [7:0] chip_byte;
    logic       buf_batch;
    logic [4:0] buf_index;
    logic [7:0] buf_data;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] chip_cmd;
    logic [5:0] chip_addr;
    logic [7:0] chip_data;
    logic [7:0] host_data;
    logic       busy_res;
    logic [1:0] bad_flags;
    logic       last;
  } out_item_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_REQ,
    DP_HOST,
    DP_BUF_WR,
    DP_BUF_RD,
    DP_HOST_RD,
    DP_READALL,
    DP_START,
    DP_DESEL,
    DP_ERASE,
    DP_WRITE,
    DP_READ,
    DP_TAKE,
    DP_CLR_INIT,
    DP_CLR_BYTE,
    DP_MARK_BAD,
    DP_END_READ
  } dp_op_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_IF,
    J_OPCODE,
    J_OPDISP
  } jump_e;

  typedef enum logic [2:0] {
    F_NONE,
    F_NO_BYTE,
    F_BELOW_SUM,
    F_SUM_MATCH,
    F_CLR_MORE
  } flag_e;

  typedef struct packed {
    dp_op_e          dp;
    jump_e           jmp;
    flag_e           flag;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] operation;
    logic       no_byte;
    logic       below_sum;
    logic       sum_match;
    logic       clr_more;
  } flags_t;

endpackage

### rtl/ebcc_ram.sv
module ebcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ebcc_seq.sv
module ebcc_seq
  import ebcc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   fire_i,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  localparam logic [PC_W-1:0] STEP_FETCH    = 5'd0;
  localparam logic [PC_W-1:0] STEP_DISP     = 5'd1;
  localparam logic [PC_W-1:0] STEP_REQ      = 5'd2;
  localparam logic [PC_W-1:0] STEP_HOST     = 5'd3;
  localparam logic [PC_W-1:0] STEP_BUF_WR   = 5'd4;
  localparam logic [PC_W-1:0] STEP_BUF_RD   = 5'd5;
  localparam logic [PC_W-1:0] STEP_HOST_RD  = 5'd6;
  localparam logic [PC_W-1:0] STEP_READALL  = 5'd7;
  localparam logic [PC_W-1:0] STEP_PASS     = 5'd8;
  localparam logic [PC_W-1:0] STEP_DESEL    = 5'd9;
  localparam logic [PC_W-1:0] STEP_ERASE    = 5'd10;
  localparam logic [PC_W-1:0] STEP_WRITE    = 5'd11;
  localparam logic [PC_W-1:0] STEP_READ     = 5'd12;
  localparam logic [PC_W-1:0] STEP_CB_CHECK = 5'd13;
  localparam logic [PC_W-1:0] STEP_CB_TAKE  = 5'd14;
  localparam logic [PC_W-1:0] STEP_CB_SUM   = 5'd15;
  localparam logic [PC_W-1:0] STEP_CB_INIT  = 5'd16;
  localparam logic [PC_W-1:0] STEP_CB_CLR   = 5'd17;
  localparam logic [PC_W-1:0] STEP_CB_BAD   = 5'd18;
  localparam logic [PC_W-1:0] STEP_CB_END   = 5'd19;

  function automatic ctrl_t cw(dp_op_e dp, jump_e jmp, flag_e flag, logic [PC_W-1:0] tgt);
    ctrl_t c;
    c.dp     = dp;
    c.jmp    = jmp;
    c.flag   = flag;
    c.target = tgt;
    return c;
  endfunction

  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    unique case (pc)
      STEP_FETCH:    c = cw(DP_LATCH,    J_NEXT,   F_NONE,      STEP_FETCH);
      STEP_DISP:     c = cw(DP_NOP,      J_OPCODE, F_NONE,      STEP_FETCH);
      STEP_REQ:      c = cw(DP_REQ,      J_NEXT,   F_NONE,      STEP_FETCH);
      STEP_HOST:     c = cw(DP_HOST,     J_GOTO,   F_NONE,      STEP_FETCH);
      STEP_BUF_WR:   c = cw(DP_BUF_WR,   J_GOTO,   F_NONE,      STEP_FETCH);
      STEP_BUF_RD:   c = cw(DP_BUF_RD,   J_NEXT,   F_NONE,      STEP_FETCH);
      STEP_HOST_RD:  c = cw(DP_HOST_RD,  J_GOTO,   F_NONE,      STEP_FETCH);
      STEP_READALL:  c = cw(DP_READALL,  J_GOTO,   F_NONE,      STEP_PASS);
      STEP_PASS:     c = cw(DP_START,    J_NEXT,   F_NONE,      STEP_FETCH);
      STEP_DESEL:    c = cw(DP_DESEL,    J_OPDISP, F_NONE,      STEP_FETCH);
      STEP_ERASE:    c = cw(DP_ERASE,    J_GOTO,   F_NONE,      STEP_FETCH);
      STEP_WRITE:    c = cw(DP_WRITE,    J_GOTO,   F_NONE,      STEP_FETCH);
      STEP_READ:     c = cw(DP_READ,     J_GOTO,   F_NONE,      STEP_FETCH);
      STEP_CB_CHECK: c = cw(DP_NOP,      J_IF,     F_NO_BYTE,   STEP_FETCH);
      STEP_CB_TAKE:  c = cw(DP_TAKE,     J_IF,     F_BELOW_SUM, STEP_PASS);
      STEP_CB_SUM:   c = cw(DP_NOP,      J_IF,     F_SUM_MATCH, STEP_CB_END);
      STEP_CB_INIT:  c = cw(DP_CLR_INIT, J_NEXT,   F_NONE,      STEP_FETCH);
      STEP_CB_CLR:   c = cw(DP_CLR_BYTE, J_IF,     F_CLR_MORE,  STEP_CB_CLR);
      STEP_CB_BAD:   c = cw(DP_MARK_BAD, J_NEXT,   F_NONE,      STEP_FETCH);
      STEP_CB_END:   c = cw(DP_END_READ, J_GOTO,   F_NONE,      STEP_PASS);
      default:       c = cw(DP_NOP,      J_GOTO,   F_NONE,      STEP_FETCH);
    endcase
    return c;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  logic            cond;

  assign ctrl_o = ucode(pc_q);

  always_comb begin
    unique case (ctrl_o.flag)
      F_NONE:      cond = 1'b0;
      F_NO_BYTE:   cond = flags_i.no_byte;
      F_BELOW_SUM: cond = flags_i.below_sum;
      F_SUM_MATCH: cond = flags_i.sum_match;
      F_CLR_MORE:  cond = flags_i.clr_more;
      default:     cond = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (fire_i) begin
      unique case (ctrl_o.jmp)
        J_NEXT:  pc_d = pc_q + 1'b1;
        J_GOTO:  pc_d = ctrl_o.target;
        J_IF:    pc_d = cond ? ctrl_o.target : pc_q + 1'b1;
        J_OPCODE: begin
          unique case (flags_i.op)
            OP_TICK:      pc_d = STEP_PASS;
            OP_REQUEST:   pc_d = STEP_REQ;
            OP_READ_ALL:  pc_d = STEP_READALL;
            OP_CHIP_BYTE: pc_d = STEP_CB_CHECK;
            OP_BUF_WRITE: pc_d = STEP_BUF_WR;
            OP_BUF_READ:  pc_d = STEP_BUF_RD;
            OP_STATUS:    pc_d = STEP_HOST;
            default:      pc_d = STEP_FETCH;
          endcase
        end
        J_OPDISP: begin
          unique case (flags_i.operation)
            OPER_IDLE:  pc_d = STEP_FETCH;
            OPER_ERASE: pc_d = STEP_ERASE;
            OPER_WRITE: pc_d = STEP_WRITE;
            OPER_READ:  pc_d = STEP_READ;
            default:    pc_d = STEP_FETCH;
          endcase
        end
        default: pc_d = STEP_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/earom_batch_checksum_controller_core.sv
// channel  dir  handshake               payload
// in       in   in_valid_i / in_stall_o  in_item_i  (in_item_t)
// out      out  out_valid_o / out_stall_i out_item_o (out_item_t)
//
// one item at a time, one control step a cycle unless a step waits on a channel;
// a chip byte whose sum fails clears the batch (27 or 32) in the buffer, one byte a cycle
// reset clears all control state and the buffer valid bits at once, no clearing pass
// a step that issues a result waits while the output register is full and stalled
`include "assert_macros.svh"

module earom_batch_checksum_controller_core
  import ebcc_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int AW   = $clog2(BUFFER_DEPTH);
  localparam int HALF = BUFFER_DEPTH / 2;

  function automatic logic [AW-1:0] bpos(logic b, logic [5:0] idx);
    return (b ? AW'(HALF) : AW'(0)) + AW'(idx);
  endfunction

  ctrl_t  ctrl;
  flags_t flags;
  logic   fire, emit, out_free;

  in_item_t  item_q, item_d;
  logic [1:0] oper_q, oper_d, pend_q, pend_d, wmode_q, wmode_d, bad_q, bad_d;
  logic       zmode_q, zmode_d, cur_q, cur_d, await_q, await_d;
  logic [5:0] bidx_q, bidx_d, caddr_q, caddr_d;
  logic [7:0] sum_q, sum_d;
  logic [BUFFER_DEPTH-1:0] vld_q;
  logic       rvld_q;
  out_item_t  out_q, res;
  logic       out_valid_q;

  logic          we, re;
  logic [AW-1:0] waddr, raddr, pos;
  logic [7:0]    wdata, rdata, rd_byte, wr_byte;
  logic [5:0]    sum_addr, clr_last;
  logic          below_sum, busy;

  ebcc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  ebcc_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sum_addr  = cur_q ? SUM_ADDR1 : SUM_ADDR0;
  assign clr_last  = cur_q ? LAST_IDX1 : LAST_IDX0;
  assign below_sum = caddr_q < sum_addr;
  assign pos       = bpos(cur_q, bidx_q);
  assign rd_byte   = rvld_q ? rdata : 8'h00;
  assign wr_byte   = !below_sum ? sum_q : (zmode_q ? 8'h00 : rd_byte);
  assign busy      = (oper_q != OPER_IDLE) || (pend_q != 2'b00) || await_q;

  assign flags.op        = item_q.op;
  assign flags.operation = oper_q;
  assign flags.no_byte   = !await_q || (oper_q != OPER_READ);
  assign flags.below_sum = below_sum;
  assign flags.sum_match = item_q.chip_byte == sum_q;
  assign flags.clr_more  = bidx_q != clr_last;

  always_comb begin
    case (ctrl.dp) inside
      DP_DESEL, DP_ERASE, DP_WRITE, DP_READ, DP_BUF_WR, DP_HOST, DP_HOST_RD: emit = 1'b1;
      default: emit = 1'b0;
    endcase
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = emit ? out_free : ((ctrl.dp == DP_LATCH) ? in_valid_i : 1'b1);
  assign in_stall_o = ctrl.dp != DP_LATCH;

  always_comb begin
    item_d  = item_q;
    oper_d  = oper_q;
    pend_d  = pend_q;
    wmode_d = wmode_q;
    zmode_d = zmode_q;
    bad_d   = bad_q;
    cur_d   = cur_q;
    bidx_d  = bidx_q;
    caddr_d = caddr_q;
    sum_d   = sum_q;
    await_d = await_q;
    we      = 1'b0;
    waddr   = pos;
    wdata   = 8'h00;
    re      = 1'b0;
    raddr   = pos;
    res     = '0;
    if (fire) begin
      unique case (ctrl.dp)
        DP_NOP: ;
        DP_LATCH: item_d = in_item_i;
        DP_REQ: begin
          zmode_d = item_q.zero_fill;
          pend_d  = pend_q | item_q.batch_bits;
          wmode_d = wmode_q | item_q.batch_bits;
        end
        DP_HOST, DP_HOST_RD, DP_BUF_WR: begin
          res.kind      = KIND_HOST;
          res.busy_res  = busy;
          res.bad_flags = bad_q;
          res.last      = 1'b1;
          if (ctrl.dp == DP_HOST_RD) begin
            res.host_data = rd_byte;
          end
          if (ctrl.dp == DP_BUF_WR) begin
            we    = 1'b1;
            waddr = bpos(item_q.buf_batch, {1'b0, item_q.buf_index});
            wdata = item_q.buf_data;
          end
        end
        DP_BUF_RD: begin
          re    = 1'b1;
          raddr = bpos(item_q.buf_batch, {1'b0, item_q.buf_index});
        end
        DP_READALL: begin
          pend_d  = 2'b11;
          wmode_d = 2'b00;
        end
        DP_START: begin
          if ((oper_q == OPER_IDLE) && (pend_q != 2'b00)) begin
            cur_d              = pend_q[1];
            oper_d             = wmode_q[pend_q[1]] ? OPER_ERASE : OPER_READ;
            pend_d[pend_q[1]]  = 1'b0;
            bidx_d             = '0;
            sum_d              = '0;
            caddr_d            = pend_q[1] ? FIRST_ADDR1 : FIRST_ADDR0;
          end
        end
        DP_DESEL: begin
          res.kind     = KIND_CHIP;
          res.chip_cmd = CMD_DESELECT;
          res.last     = oper_q == OPER_IDLE;
          re           = 1'b1;
        end
        DP_ERASE: begin
          res.kind      = KIND_CHIP;
          res.chip_cmd  = CMD_ERASE;
          res.chip_addr = caddr_q;
          res.last      = 1'b1;
          oper_d        = OPER_WRITE;
        end
        DP_WRITE: begin
          res.kind      = KIND_CHIP;
          res.chip_cmd  = CMD_WRITE;
          res.chip_addr = caddr_q;
          res.chip_data = wr_byte;
          res.last      = 1'b1;
          if (below_sum) begin
            oper_d = OPER_ERASE;
            we     = zmode_q;
          end else begin
            oper_d = OPER_IDLE;
          end
          sum_d   = sum_q + wr_byte;
          bidx_d  = bidx_q + 6'd1;
          caddr_d = caddr_q + 6'd1;
        end
        DP_READ: begin
          res.kind      = KIND_CHIP;
          res.chip_cmd  = CMD_READ;
          res.chip_addr = caddr_q;
          res.last      = 1'b1;
          await_d       = 1'b1;
        end
        DP_TAKE: begin
          await_d = 1'b0;
          if (below_sum) begin
            we      = 1'b1;
            wdata   = item_q.chip_byte;
            sum_d   = sum_q + item_q.chip_byte;
            bidx_d  = bidx_q + 6'd1;
            caddr_d = caddr_q + 6'd1;
          end
        end
        DP_CLR_INIT: bidx_d = '0;
        DP_CLR_BYTE: begin
          we     = 1'b1;
          bidx_d = bidx_q + 6'd1;
        end
        DP_MARK_BAD: bad_d[cur_q] = 1'b1;
        DP_END_READ: begin
          oper_d  = OPER_IDLE;
          bidx_d  = bidx_q + 6'd1;
          caddr_d = caddr_q + 6'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oper_q      <= OPER_IDLE;
      pend_q      <= '0;
      wmode_q     <= '0;
      zmode_q     <= 1'b0;
      bad_q       <= '0;
      cur_q       <= 1'b0;
      bidx_q      <= '0;
      caddr_q     <= '0;
      sum_q       <= '0;
      await_q     <= 1'b0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      oper_q  <= oper_d;
      pend_q  <= pend_d;
      wmode_q <= wmode_d;
      zmode_q <= zmode_d;
      bad_q   <= bad_d;
      cur_q   <= cur_d;
      bidx_q  <= bidx_d;
      caddr_q <= caddr_d;
      sum_q   <= sum_d;
      await_q <= await_d;
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_q <= vld_q[raddr];
      end
      if (emit && fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (emit && fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_IMPL(a_await_in_read, await_q, oper_q == OPER_READ)
  `ASSERT_IMPL(a_addr_in_batch, oper_q != OPER_IDLE, caddr_q <= sum_addr)
  `ASSERT_IMPL(a_clear_in_batch, ctrl.dp == DP_CLR_BYTE, bidx_q <= clr_last)
  `ASSERT_NEXT(a_emit_shows, emit && fire, out_valid_o)

endmodule
